>>> hdl/itp_pkg.sv
`default_nettype none

package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Characters with a role in the conversion
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNMATCHED  = 2'd1,
        ST_OVERFLOW   = 2'd2
    } status_t;

    // Pop loop flavor
    typedef enum logic [1:0] {
        MODE_CLOSE = 2'd0,
        MODE_OP    = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_RD       = 6'b000100,
        S_TEST     = 6'b001000,
        S_PUSH     = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    // Precedence; "other" (-1) maps to 0, operators keep their rank, order holds
    function automatic logic [1:0] rank_of(input logic [7:0] ch);
        logic [1:0] r;
        begin
            r = 2'd0;
            if (ch == CH_CARET)
                r = 2'd3;
            else if (ch == CH_STAR || ch == CH_SLASH)
                r = 2'd2;
            else if (ch == CH_PLUS || ch == CH_MINUS)
                r = 2'd1;
            return r;
        end
    endfunction

    // Letters and digits
    function automatic logic is_operand(input logic [7:0] ch);
        begin
            return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
                   (ch >= 8'h30 && ch <= 8'h39);
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/infix_to_postfix_converter_unit.sv
`default_nettype none

// Shunting-yard infix to postfix converter. One character is taken per input
// transaction; postfix characters come out one per output transaction, the
// last one caused by a character flagged with run_last, and the last one of a
// character marked is_last also flagged with expr_end. A character that causes
// no result (for example a '(' that is not last) produces nothing. The block
// takes a new character only when the previous one is completely processed.
// An operand is emitted directly and a '(' is pushed; an operator pops the
// entries that rank at least as high, then is pushed, and a ')' pops entries
// up to its '('. Each stack entry that is examined passes through a registered
// read of the operator stack memory, then the test, and a character marked
// is_last then flushes every entry left. The sequencer waits while the output
// side stalls a result. An unmatched ')' or an overflow of the 32-entry stack
// emits one error result with out_char zero and empties the stack.
module infix_to_postfix_converter_unit
    import itp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       is_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_char,
    output logic [1:0]      status,
    output logic            run_last,
    output logic            expr_end
);

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         ch_reg;
    logic               last_reg;

    logic [7:0]         op_stack [STACK_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [PTR_W-1:0]   top_idx;
    logic               mem_we;

    logic               pend_valid_reg;
    logic [7:0]         pend_char_reg;
    status_t            pend_status_reg;

    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic [1:0]         out_status_reg;
    logic               run_last_reg;
    logic               expr_end_reg;

    logic               out_free, can_emit, emit_req, emit_fire, fin_load, out_load;
    logic [7:0]         emit_char;
    status_t            emit_status;
    logic               stack_full;
    logic [CNT_W-1:0]   count_dec;
    state_t             post_state;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign can_emit   = !pend_valid_reg || out_free;
    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_dec  = count_reg - CNT_W'(1);
    assign top_idx    = count_dec[PTR_W-1:0];
    assign post_state = last_reg ? S_RD : S_FINISH;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        emit_req    = 1'b0;
        emit_char   = ch_reg;
        emit_status = ST_OK;
        fin_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                if (is_operand(ch_reg))
                begin
                    emit_req = 1'b1;
                    if (can_emit)
                    begin
                        state_next = post_state;
                        mode_next  = MODE_FLUSH;
                    end
                end
                else if (ch_reg == CH_LPAREN)
                    state_next = S_PUSH;
                else if (ch_reg == CH_RPAREN)
                begin
                    mode_next  = MODE_CLOSE;
                    state_next = S_RD;
                end
                else
                begin
                    mode_next  = MODE_OP;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (count_reg == '0)
                begin
                    case (mode_reg)
                        MODE_CLOSE:
                        begin
                            emit_req    = 1'b1;
                            emit_char   = 8'd0;
                            emit_status = ST_UNMATCHED;
                            if (can_emit)
                            begin
                                state_next = post_state;
                                mode_next  = MODE_FLUSH;
                            end
                        end
                        MODE_OP:    state_next = S_PUSH;
                        default:    state_next = S_FINISH;
                    endcase
                end
                else
                    state_next = S_TEST;
            end
            S_TEST:
            begin
                case (mode_reg)
                    MODE_CLOSE:
                    begin
                        if (rd_data_reg == CH_LPAREN)
                        begin
                            count_next = count_dec;
                            state_next = post_state;
                            mode_next  = MODE_FLUSH;
                        end
                        else
                        begin
                            emit_req  = 1'b1;
                            emit_char = rd_data_reg;
                            if (can_emit)
                            begin
                                count_next = count_dec;
                                state_next = S_RD;
                            end
                        end
                    end
                    MODE_OP:
                    begin
                        // precedence compare, a tie pops the stack entry
                        if (rank_of(ch_reg) <= rank_of(rd_data_reg))
                        begin
                            emit_req  = 1'b1;
                            emit_char = rd_data_reg;
                            if (can_emit)
                            begin
                                count_next = count_dec;
                                state_next = S_RD;
                            end
                        end
                        else
                            state_next = S_PUSH;
                    end
                    default:
                    begin
                        emit_req  = 1'b1;
                        emit_char = rd_data_reg;
                        if (can_emit)
                        begin
                            count_next = count_dec;
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_PUSH:
            begin
                if (stack_full)
                begin
                    emit_req    = 1'b1;
                    emit_char   = 8'd0;
                    emit_status = ST_OVERFLOW;
                    if (can_emit)
                    begin
                        count_next = '0;
                        state_next = post_state;
                        mode_next  = MODE_FLUSH;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = post_state;
                    mode_next  = MODE_FLUSH;
                end
            end
            S_FINISH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    fin_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign emit_fire = emit_req && can_emit;
    assign out_load  = (emit_fire && pend_valid_reg) || fin_load;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FLUSH;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            if (emit_fire)
                pend_valid_reg <= 1'b1;
            else if (fin_load)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Input latch, pending result and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ch_reg   <= char_code;
            last_reg <= is_last;
        end
        if (emit_fire)
        begin
            pend_char_reg   <= emit_char;
            pend_status_reg <= emit_status;
        end
        if (out_load)
        begin
            out_char_reg   <= pend_char_reg;
            out_status_reg <= pend_status_reg;
            run_last_reg   <= fin_load;
            expr_end_reg   <= fin_load && last_reg;
        end
    end

    // Operator stack memory: one write port, registered read of the top
    always_ff @(posedge clk)
    begin
        if (mem_we)
            op_stack[count_reg[PTR_W-1:0]] <= ch_reg;
        rd_data_reg <= op_stack[top_idx];
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = out_status_reg;
    assign run_last  = run_last_reg;
    assign expr_end  = expr_end_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left over at idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while held");

    a_finish_tag: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> out_valid_reg && run_last_reg)
        else $error("closing result not flagged");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !stack_full)
        else $error("write into full stack");

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb
    import itp_pkg::*;
();

    // One expected postfix output transaction
    typedef struct packed {
        logic [7:0] ch;
        status_t    st;
        logic       run_last;
        logic       expr_end;
    } postfix_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_code;
    logic       is_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic [1:0] status;
    logic       run_last;
    logic       expr_end;

    // Shadow operator stack of the converter
    logic [7:0] op_held [STACK_DEPTH];
    int         op_count;

    postfix_t   postfix_due [$];
    logic [7:0] expr_buf [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatch_count;
    int chars_sent;
    int results_seen;
    int error_results;
    int exprs_sent;

    logic [7:0] op_set [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

    infix_to_postfix_converter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .status    (status),
        .run_last  (run_last),
        .expr_end  (expr_end)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d postfix results still outstanding", postfix_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Binding strength of a character; anything that is not an operator binds at -1
    function automatic int binding_power(input logic [7:0] ch);
        if (ch == CH_CARET)
            return 3;
        if (ch == CH_STAR || ch == CH_SLASH)
            return 2;
        if (ch == CH_PLUS || ch == CH_MINUS)
            return 1;
        return -1;
    endfunction

    function automatic bit is_letter_or_digit(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
               (ch >= 8'h30 && ch <= 8'h39);
    endfunction

    function automatic postfix_t postfix_entry(input logic [7:0] ch, input status_t st);
        postfix_t e;
        e.ch       = ch;
        e.st       = st;
        e.run_last = 1'b0;
        e.expr_end = 1'b0;
        return e;
    endfunction

    // Shunting-yard step: update the shadow stack and queue the postfix output
    function automatic void predict_postfix(input logic [7:0] ch, input logic last);
        postfix_t batch [$];
        bit       found;
        int       pw;
        found = 1'b0;
        if (is_letter_or_digit(ch))
            batch.push_back(postfix_entry(ch, ST_OK));
        else if (ch == CH_LPAREN)
        begin
            if (op_count >= STACK_DEPTH)
            begin
                op_count = 0;
                batch.push_back(postfix_entry(8'h00, ST_OVERFLOW));
            end
            else
            begin
                op_held[op_count] = ch;
                op_count++;
            end
        end
        else if (ch == CH_RPAREN)
        begin
            // pop until the matching open paren
            while (op_count > 0 && !found)
            begin
                op_count--;
                if (op_held[op_count] == CH_LPAREN)
                    found = 1'b1;
                else
                    batch.push_back(postfix_entry(op_held[op_count], ST_OK));
            end
            if (!found)
                batch.push_back(postfix_entry(8'h00, ST_UNMATCHED));
        end
        else
        begin
            pw = binding_power(ch);
            while (op_count > 0 && pw <= binding_power(op_held[op_count - 1]))
            begin
                op_count--;
                batch.push_back(postfix_entry(op_held[op_count], ST_OK));
            end
            if (op_count >= STACK_DEPTH)
            begin
                op_count = 0;
                batch.push_back(postfix_entry(8'h00, ST_OVERFLOW));
            end
            else
            begin
                op_held[op_count] = ch;
                op_count++;
            end
        end
        // end of expression: flush top first
        if (last)
        begin
            while (op_count > 0)
            begin
                op_count--;
                batch.push_back(postfix_entry(op_held[op_count], ST_OK));
            end
        end
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].run_last = 1'b1;
            batch[batch.size() - 1].expr_end = last;
        end
        postfix_due = {postfix_due, batch};
    endfunction

    // Receiver stall pattern
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Output checker
    always @(posedge clk)
    begin
        postfix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (status != ST_OK)
                error_results++;
            if (postfix_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got char %h status %0d",
                         $time, out_char, status);
                mismatch_count++;
            end
            else
            begin
                want = postfix_due.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %h got %h", $time, want.ch, out_char);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, status);
                    mismatch_count++;
                end
                if (run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %b got %b", $time, want.run_last,
                             run_last);
                    mismatch_count++;
                end
                if (expr_end !== want.expr_end)
                begin
                    $display("%0t: expr_end expected %b got %b", $time, want.expr_end,
                             expr_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one character; entered and left at a falling edge with valid low
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        is_last   <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_postfix(ch, last);
        chars_sent++;
        @(negedge clk);
        // converter is still busy at this point
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_expr(input bit mark_last);
        for (int i = 0; i < expr_buf.size(); i++)
            send_char(expr_buf[i], mark_last && (i == expr_buf.size() - 1));
        exprs_sent++;
    endtask

    task automatic send_text(input string s, input bit mark_last);
        expr_buf = {};
        for (int i = 0; i < s.len(); i++)
            expr_buf.push_back(s[i]);
        send_expr(mark_last);
    endtask

    // Hold the input side idle until every expected result has come out
    task automatic drain();
        while (postfix_due.size() > 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] random_operand();
        case ($urandom_range(2))
            0:       return 8'h61 + 8'($urandom_range(25));
            1:       return 8'h41 + 8'($urandom_range(25));
            default: return 8'h30 + 8'($urandom_range(9));
        endcase
    endfunction

    // Well-formed random expression into expr_buf
    function automatic void build_expr();
        int nterms;
        int open;
        nterms = $urandom_range(1, 6);
        open   = 0;
        for (int i = 0; i < nterms; i++)
        begin
            while ($urandom_range(3) == 0 && open < 6)
            begin
                expr_buf.push_back(CH_LPAREN);
                open++;
            end
            expr_buf.push_back(random_operand());
            while (open > 0 && $urandom_range(2) == 0)
            begin
                expr_buf.push_back(CH_RPAREN);
                open--;
            end
            if (i < nterms - 1)
                expr_buf.push_back(op_set[$urandom_range(4)]);
        end
        while (open > 0)
        begin
            expr_buf.push_back(CH_RPAREN);
            open--;
        end
    endfunction

    // Operator precedence and associativity
    task automatic test_precedence();
        send_text("a+b*c^d", 1'b1);
        send_text("A^B^C", 1'b1);
        send_text("0/9-z", 1'b1);
    endtask

    // Matched parens and characters outside the operator set
    task automatic test_paren_and_unknown();
        send_text("(1-Z)/9", 1'b1);
        send_text("(x+", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Unmatched close paren, error on the last item, last item with no output
    task automatic test_error_cases();
        send_text(")", 1'b1);
        send_text("()", 1'b1);
        send_text("+)", 1'b0);
        send_text("z", 1'b1);
    endtask

    // Full stack: push of an open paren, then of an operator
    task automatic test_overflow();
        expr_buf = {};
        repeat (STACK_DEPTH + 1)
            expr_buf.push_back(CH_LPAREN);
        send_expr(1'b0);
        send_text("a", 1'b1);
        expr_buf = {};
        repeat (STACK_DEPTH - 1)
            expr_buf.push_back(CH_LPAREN);
        expr_buf.push_back(CH_PLUS);
        expr_buf.push_back(CH_STAR);
        send_expr(1'b1);
    endtask

    // Random expressions, noise and broken input under three idle patterns
    task automatic test_random_traffic();
        int phase_start;
        int pick;
        int idx;
        bit mark;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 6;
                    receiver_stall_pct = 78;
                end
                1:
                begin
                    sender_idle_pct    = 78;
                    receiver_stall_pct = 6;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            phase_start = chars_sent;
            while (chars_sent - phase_start < 115)
            begin
                expr_buf = {};
                pick     = $urandom_range(99);
                if (pick < 75)
                begin
                    build_expr();
                    mark = ($urandom_range(9) != 0);
                end
                else if (pick < 88)
                begin
                    // arbitrary bytes
                    repeat ($urandom_range(1, 8))
                        expr_buf.push_back(8'($urandom_range(255)));
                    mark = 1'($urandom_range(1));
                end
                else if ($urandom_range(1) == 0)
                begin
                    // deep nesting around the stack limit
                    repeat ($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4))
                        expr_buf.push_back(CH_LPAREN);
                    build_expr();
                    mark = 1'b1;
                end
                else
                begin
                    // stray close paren or a dropped character
                    build_expr();
                    idx = $urandom_range(expr_buf.size() - 1);
                    if ($urandom_range(1) == 0 || expr_buf.size() < 2)
                        expr_buf.insert(idx, CH_RPAREN);
                    else
                        expr_buf.delete(idx);
                    mark = 1'b1;
                end
                send_expr(mark);
            end
            drain();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        char_code          = 8'h00;
        is_last            = 1'b0;
        out_stall          = 1'b0;
        op_count           = 0;
        mismatch_count     = 0;
        chars_sent         = 0;
        results_seen       = 0;
        error_results      = 0;
        exprs_sent         = 0;
        sender_idle_pct    = 20;
        receiver_stall_pct = 30;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_precedence();
        test_paren_and_unknown();
        test_error_cases();
        test_overflow();
        drain();
        test_random_traffic();

        drain();
        repeat (150) @(negedge clk);
        if (postfix_due.size() > 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, postfix_due.size());
            mismatch_count++;
        end

        $display("Run: %0d characters in %0d expressions, %0d postfix results checked",
                 chars_sent, exprs_sent, results_seen);
        $display("Error results seen (unmatched paren or stack overflow): %0d",
                 error_results);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/itp_pkg.sv
hdl/infix_to_postfix_converter_unit.sv
tb/tb.sv
